// ===== hdl/rpq_pkg.sv =====
// ----------------------------------------------------------------------------
// rpq_pkg
// Shared types and constants for the ready priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rpq_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int ID_W            = 8;
  localparam int PRI_W           = 4;
  localparam int S_TDATA_W       = 16;
  localparam int M_TDATA_W       = 16;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_SELECT,
    OP_RESCHED,
    OP_SET_READY
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_NOT_FOUND,
    ST_NO_READY
  } status_t;

  // kind of walk over the table
  typedef enum logic [1:0] {
    WK_INSERT,
    WK_SELECT,
    WK_FIND,
    WK_MOVE
  } walk_t;

  typedef enum logic [1:0] {
    CMP_PRI_GE,
    CMP_READY,
    CMP_ID
  } cmp_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             ready;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  req_id;
    logic [PRI_W-1:0] priority_req;
    logic             ready_req;
  } req_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] chosen_id;
    logic            is_empty;
  } res_t;

  localparam int M_PAD_W = M_TDATA_W - 2 - ID_W - 1;

endpackage

`default_nettype wire

// ===== hdl/rpq_ram.sv =====
// ----------------------------------------------------------------------------
// rpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/rpq_cmp.sv =====
// ----------------------------------------------------------------------------
// rpq_cmp
// Shared compare unit: tests one table entry against the current key.
// ----------------------------------------------------------------------------
`default_nettype none

module rpq_cmp (
  input  wire rpq_pkg::cmp_mode_t            mode,
  input  wire rpq_pkg::entry_t               ent,
  input  wire logic [rpq_pkg::ID_W-1:0]      key_id,
  input  wire logic [rpq_pkg::PRI_W-1:0]     key_pri,
  output logic                               hit
);

  always_comb begin
    case (mode)
      rpq_pkg::CMP_PRI_GE: hit = (ent.pri >= key_pri);
      rpq_pkg::CMP_READY:  hit = ent.ready;
      rpq_pkg::CMP_ID:     hit = (ent.id == key_id);
      default:             hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/rpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpq_ctrl
// Sequencer that walks the ordered table one entry at a time through the
// table RAM and the shared compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rpq_ctrl #(
  parameter int MAX_ENTRIES = rpq_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire rpq_pkg::req_t req,
  output logic               idle,
  output logic               done,
  output rpq_pkg::res_t      res,
  input  wire logic          take
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  rpq_pkg::state_t  state, state_next;
  rpq_pkg::walk_t   walk;
  rpq_pkg::req_t    req_q;
  rpq_pkg::entry_t  hold;
  rpq_pkg::status_t status;
  logic [rpq_pkg::ID_W-1:0] chosen;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    count;

  logic                         ram_we;
  logic [AW-1:0]                ram_wa;
  logic [rpq_pkg::ENTRY_W-1:0]  ram_wd;
  logic [AW-1:0]                ram_ra;
  logic [rpq_pkg::ENTRY_W-1:0]  ram_rd;
  rpq_pkg::entry_t              rd_ent;

  rpq_pkg::cmp_mode_t           cmp_mode;
  logic [rpq_pkg::PRI_W-1:0]    cmp_pri;
  logic                         hit;
  logic                         at_end;
  logic                         full;

  assign rd_ent = rpq_pkg::entry_t'(ram_rd);
  assign full   = (count == CW'(MAX_ENTRIES));

  // insert walks down from the tail, all other walks go up
  assign at_end = (walk == rpq_pkg::WK_INSERT) ? (idx == '0) : (idx == count);

  rpq_ram #(
    .WIDTH (rpq_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  rpq_cmp u_cmp (
    .mode    (cmp_mode),
    .ent     (rd_ent),
    .key_id  (req_q.req_id),
    .key_pri (cmp_pri),
    .hit     (hit)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rpq_pkg::S_IDLE: begin
        if (start) begin
          if (req.op == rpq_pkg::OP_INSERT && full) begin
            state_next = rpq_pkg::S_DONE;
          end else begin
            state_next = rpq_pkg::S_READ;
          end
        end
      end
      rpq_pkg::S_READ: begin
        if (at_end) begin
          if (walk == rpq_pkg::WK_INSERT || walk == rpq_pkg::WK_MOVE) begin
            state_next = rpq_pkg::S_WRITE;
          end else begin
            state_next = rpq_pkg::S_DONE;
          end
        end else begin
          state_next = rpq_pkg::S_CHECK;
        end
      end
      rpq_pkg::S_CHECK: begin
        case (walk)
          rpq_pkg::WK_INSERT: state_next = hit ? rpq_pkg::S_WRITE : rpq_pkg::S_READ;
          rpq_pkg::WK_SELECT: state_next = hit ? rpq_pkg::S_DONE : rpq_pkg::S_READ;
          rpq_pkg::WK_FIND: begin
            if (hit && req_q.op == rpq_pkg::OP_SET_READY) begin
              state_next = rpq_pkg::S_DONE;
            end else begin
              state_next = rpq_pkg::S_READ;
            end
          end
          rpq_pkg::WK_MOVE:   state_next = hit ? rpq_pkg::S_READ : rpq_pkg::S_WRITE;
          default:            state_next = rpq_pkg::S_IDLE;
        endcase
      end
      rpq_pkg::S_WRITE: state_next = rpq_pkg::S_DONE;
      rpq_pkg::S_DONE: begin
        if (take) begin
          state_next = rpq_pkg::S_IDLE;
        end
      end
      default: state_next = rpq_pkg::S_IDLE;
    endcase
  end

  // RAM and compare controls
  always_comb begin
    rpq_pkg::entry_t tmp;
    tmp      = rd_ent;
    ram_we   = 1'b0;
    ram_wa   = idx[AW-1:0];
    ram_wd   = ram_rd;
    ram_ra   = idx[AW-1:0];
    cmp_mode = rpq_pkg::CMP_ID;
    cmp_pri  = req_q.priority_req;

    case (walk)
      rpq_pkg::WK_INSERT: begin
        cmp_mode = rpq_pkg::CMP_PRI_GE;
        ram_ra   = AW'(idx - CW'(1));
      end
      rpq_pkg::WK_SELECT: cmp_mode = rpq_pkg::CMP_READY;
      rpq_pkg::WK_FIND:   cmp_mode = rpq_pkg::CMP_ID;
      rpq_pkg::WK_MOVE: begin
        cmp_mode = rpq_pkg::CMP_PRI_GE;
        cmp_pri  = hold.pri;
      end
      default: cmp_mode = rpq_pkg::CMP_ID;
    endcase

    case (state)
      rpq_pkg::S_CHECK: begin
        case (walk)
          rpq_pkg::WK_INSERT: begin
            // shift entry one slot toward the tail
            ram_we = !hit;
          end
          rpq_pkg::WK_FIND: begin
            tmp.ready = req_q.ready_req;
            ram_wd    = tmp;
            ram_we    = hit && (req_q.op == rpq_pkg::OP_SET_READY);
          end
          rpq_pkg::WK_MOVE: begin
            // pull same-priority entry up over the moved one
            ram_we = hit;
            ram_wa = AW'(idx - CW'(1));
          end
          default: ram_we = 1'b0;
        endcase
      end
      rpq_pkg::S_WRITE: begin
        ram_we = 1'b1;
        if (walk == rpq_pkg::WK_MOVE) begin
          ram_wa = AW'(idx - CW'(1));
          ram_wd = hold;
        end else begin
          ram_wd = {req_q.ready_req, req_q.priority_req, req_q.req_id};
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpq_pkg::S_IDLE;
      count <= '0;
      walk  <= rpq_pkg::WK_SELECT;
    end else begin
      state <= state_next;
      case (state)
        rpq_pkg::S_IDLE: begin
          if (start) begin
            req_q  <= req;
            chosen <= '0;
            case (req.op)
              rpq_pkg::OP_INSERT: begin
                walk <= rpq_pkg::WK_INSERT;
                idx  <= count;
                if (full) begin
                  status <= rpq_pkg::ST_FULL;
                end else begin
                  status <= rpq_pkg::ST_OK;
                end
              end
              rpq_pkg::OP_SELECT: begin
                walk   <= rpq_pkg::WK_SELECT;
                idx    <= '0;
                status <= rpq_pkg::ST_OK;
              end
              default: begin
                walk   <= rpq_pkg::WK_FIND;
                idx    <= '0;
                status <= rpq_pkg::ST_OK;
              end
            endcase
          end
        end
        rpq_pkg::S_READ: begin
          if (at_end) begin
            if (walk == rpq_pkg::WK_SELECT) begin
              status <= rpq_pkg::ST_NO_READY;
            end else if (walk == rpq_pkg::WK_FIND) begin
              status <= rpq_pkg::ST_NOT_FOUND;
            end
          end
        end
        rpq_pkg::S_CHECK: begin
          case (walk)
            rpq_pkg::WK_INSERT: begin
              if (!hit) begin
                idx <= idx - CW'(1);
              end
            end
            rpq_pkg::WK_SELECT: begin
              if (hit) begin
                chosen <= rd_ent.id;
              end else begin
                idx <= idx + CW'(1);
              end
            end
            rpq_pkg::WK_FIND: begin
              if (hit && req_q.op == rpq_pkg::OP_RESCHED) begin
                hold <= rd_ent;
                walk <= rpq_pkg::WK_MOVE;
                idx  <= idx + CW'(1);
              end else if (!hit) begin
                idx <= idx + CW'(1);
              end
            end
            rpq_pkg::WK_MOVE: begin
              if (hit) begin
                idx <= idx + CW'(1);
              end
            end
            default: idx <= idx;
          endcase
        end
        rpq_pkg::S_WRITE: begin
          if (walk == rpq_pkg::WK_INSERT) begin
            count <= count + CW'(1);
          end
        end
        default: idx <= idx;
      endcase
    end
  end

  assign idle          = (state == rpq_pkg::S_IDLE);
  assign done          = (state == rpq_pkg::S_DONE);
  assign res.status    = status;
  assign res.chosen_id = chosen;
  assign res.is_empty  = (count == '0);

endmodule

`default_nettype wire

// ===== hdl/ready_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// ready_priority_queue_core
// Ordered thread table (priority, then arrival) with insert, select first
// ready, reschedule to end of priority group and set ready flag.
// ----------------------------------------------------------------------------
// channel  dir  signals                      word contents
// s        in   s_tvalid s_tready s_tdata    op in tuser, request in tdata
//               s_tuser
// m        out  m_tvalid m_tready m_tdata    status, chosen id, empty flag
//
// A request visits the table entries one at a time through the one read port
// of the table RAM (one read and one compare per entry). One request at a
// time; s_tready is high only while the sequencer is idle. The result sits
// in an output register, so the next request is taken while m_tready is
// low. Reset clears the entry count; no clearing pass over the table.
// ----------------------------------------------------------------------------
`default_nettype none

module ready_priority_queue_core #(
  parameter int MAX_ENTRIES = rpq_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [7:0] req_id, [11:8] priority_req, [12] ready_req, [15:13] zero
  input  wire logic [rpq_pkg::S_TDATA_W-1:0]   s_tdata,
  // [1:0] op
  input  wire logic [1:0]                      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [1:0] status, [9:2] chosen_id, [10] is_empty, [15:11] zero
  output logic      [rpq_pkg::M_TDATA_W-1:0]   m_tdata
);

  rpq_pkg::req_t req;
  rpq_pkg::res_t res;
  rpq_pkg::res_t out_res;
  logic          idle;
  logic          done;
  logic          take;
  logic          start;

  assign req.op           = rpq_pkg::op_t'(s_tuser);
  assign req.req_id       = s_tdata[rpq_pkg::ID_W-1:0];
  assign req.priority_req = s_tdata[rpq_pkg::ID_W +: rpq_pkg::PRI_W];
  assign req.ready_req    = s_tdata[rpq_pkg::ID_W + rpq_pkg::PRI_W];

  assign s_tready = idle;
  assign start    = s_tvalid && idle;
  // output slot free or being emptied this cycle
  assign take     = done && (!m_tvalid || m_tready);

  rpq_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .idle  (idle),
    .done  (done),
    .res   (res),
    .take  (take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{rpq_pkg::M_PAD_W{1'b0}}, out_res.is_empty, out_res.chosen_id,
                    out_res.status};

  // a full table is never empty
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.status == rpq_pkg::ST_FULL |-> !out_res.is_empty)
    else $error("full status reported with empty table");

  // only a successful select carries an id
  a_chosen_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.chosen_id != '0 |-> out_res.status == rpq_pkg::ST_OK)
    else $error("chosen id with non-ok status");

  // a handed-over result shows up on the output
  a_take_shows: assert property (@(posedge clk) disable iff (rst)
    take |=> m_tvalid)
    else $error("result lost on hand-over");

  // no request is taken while a result is still inside the sequencer
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !s_tready)
    else $error("request accepted while result pending");

endmodule

`default_nettype wire

// ===== dv/ready_priority_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// ready_priority_queue_core_tb
// Streams insert, select, reschedule and set-ready requests into the thread
// table, keeps a shadow copy of the ordered table to predict each reply word,
// and checks every reply field by field. Random gaps on both sides, plus one
// long reply hold-off that backs the request side up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ready_priority_queue_core_tb;

  localparam int N_RANDOM   = 1400;
  localparam int HOLD_AT    = 300;   // reply count that starts the long hold-off
  localparam int HOLD_LEN   = 150;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_PAD  = 2 * rpq_pkg::MAX_ENTRIES_DEF + 8;

  logic                          clk;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [rpq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
  logic [1:0]                    s_tuser  = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [rpq_pkg::M_TDATA_W-1:0] m_tdata;

  ready_priority_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  rpq_pkg::req_t   request_backlog[$];
  rpq_pkg::res_t   owed_replies[$];
  rpq_pkg::entry_t thread_slots[rpq_pkg::MAX_ENTRIES_DEF];
  int     slot_count   = 0;
  int     err_count    = 0;
  int     words_sent   = 0;
  int     replies_seen = 0;
  int     idle_cycles  = 0;
  int     hold_left    = 0;
  int     s_gap        = 0;
  int     m_wait       = 0;
  bit     s_took       = 1'b0;
  bit     m_took       = 1'b0;

  // ---- shadow table ----

  // goes after every entry of equal or higher priority
  function automatic void place_entry(rpq_pkg::entry_t e);
    int pos;
    int i;
    pos = 0;
    while (pos < slot_count && thread_slots[pos].pri >= e.pri) pos++;
    for (i = slot_count; i > pos; i--) thread_slots[i] = thread_slots[i-1];
    thread_slots[pos] = e;
    slot_count++;
  endfunction

  function automatic rpq_pkg::res_t apply_sched_op(rpq_pkg::req_t r);
    rpq_pkg::res_t   o;
    rpq_pkg::entry_t e;
    int     pos;
    int     i;
    o.status    = rpq_pkg::ST_OK;
    o.chosen_id = '0;
    o.is_empty  = 1'b0;
    case (r.op)
      rpq_pkg::OP_INSERT: begin
        if (slot_count >= rpq_pkg::MAX_ENTRIES_DEF) begin
          o.status = rpq_pkg::ST_FULL;
        end else begin
          e.id    = r.req_id;
          e.pri   = r.priority_req;
          e.ready = r.ready_req;
          place_entry(e);
        end
      end
      rpq_pkg::OP_SELECT: begin
        pos = 0;
        while (pos < slot_count && !thread_slots[pos].ready) pos++;
        if (pos < slot_count) o.chosen_id = thread_slots[pos].id;
        else o.status = rpq_pkg::ST_NO_READY;
      end
      default: begin
        // reschedule and set-ready act on the first matching id
        pos = 0;
        while (pos < slot_count && thread_slots[pos].id != r.req_id) pos++;
        if (pos >= slot_count) begin
          o.status = rpq_pkg::ST_NOT_FOUND;
        end else if (r.op == rpq_pkg::OP_SET_READY) begin
          thread_slots[pos].ready = r.ready_req;
        end else begin
          // stored priority decides the new place, priority_req is ignored
          e = thread_slots[pos];
          for (i = pos; i < slot_count - 1; i++) thread_slots[i] = thread_slots[i+1];
          slot_count--;
          place_entry(e);
        end
      end
    endcase
    o.is_empty = (slot_count == 0);
    return o;
  endfunction

  // ---- stimulus ----

  function automatic void queue_req(rpq_pkg::op_t op, int id, int pri, int rdy);
    rpq_pkg::req_t r;
    r.op           = op;
    r.req_id       = id[rpq_pkg::ID_W-1:0];
    r.priority_req = pri[rpq_pkg::PRI_W-1:0];
    r.ready_req    = rdy[0];
    request_backlog.push_back(r);
  endfunction

  // some stretches run with no idling at all
  function automatic int draw_wait(int seq);
    if ((seq / 50) % 4 == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic build_random_traffic();
    logic [rpq_pkg::ID_W-1:0] live_ids[$];
    int              k;
    int              pick;
    int              id;
    int              pri;
    for (k = 0; k < N_RANDOM; k++) begin
      pick = $urandom_range(0, 99);
      pri  = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 15) : 4 + 5 * $urandom_range(0, 2);
      if (live_ids.size() != 0 && $urandom_range(0, 99) < 85)
        id = live_ids[$urandom_range(0, live_ids.size() - 1)];
      else
        id = $urandom_range(0, 255);
      if (pick < 20) begin
        // inserts mostly bring fresh ids, sometimes a duplicate
        if ($urandom_range(0, 3) != 0) id = $urandom_range(0, 255);
        if (live_ids.size() < rpq_pkg::MAX_ENTRIES_DEF)
          live_ids.push_back(id[rpq_pkg::ID_W-1:0]);
        queue_req(rpq_pkg::OP_INSERT, id, pri, $urandom_range(0, 1));
      end else if (pick < 45) begin
        queue_req(rpq_pkg::OP_SELECT, $urandom_range(0, 255), pri, $urandom_range(0, 1));
      end else if (pick < 70) begin
        queue_req(rpq_pkg::OP_RESCHED, id, pri, $urandom_range(0, 1));
      end else begin
        queue_req(rpq_pkg::OP_SET_READY, id, pri, ($urandom_range(0, 2) == 0));
      end
    end
  endtask

  initial begin
    // empty table: no ready entry, unknown ids
    queue_req(rpq_pkg::OP_SELECT,    8'h00,  0, 0);
    queue_req(rpq_pkg::OP_RESCHED,   8'h00, 15, 1);
    queue_req(rpq_pkg::OP_SET_READY, 8'hFF,  0, 1);
    queue_req(rpq_pkg::OP_INSERT,    8'hFF, 15, 0);
    queue_req(rpq_pkg::OP_SELECT,    8'hFF, 15, 1);   // entries present, none ready
    queue_req(rpq_pkg::OP_INSERT,    8'h00,  0, 1);
    queue_req(rpq_pkg::OP_SELECT,    8'h00,  0, 0);
    queue_req(rpq_pkg::OP_INSERT,    8'h00, 15, 0);   // duplicate id
    queue_req(rpq_pkg::OP_RESCHED,   8'hFF,  0, 0);   // requested priority ignored
    queue_req(rpq_pkg::OP_SET_READY, 8'h00, 15, 1);   // hits the first id 0 only
    queue_req(rpq_pkg::OP_SELECT,    8'h00,  0, 0);
    queue_req(rpq_pkg::OP_INSERT,    8'hAA, 15, 1);
    queue_req(rpq_pkg::OP_RESCHED,   8'h00,  7, 1);
    queue_req(rpq_pkg::OP_SET_READY, 8'hFF,  0, 1);
    queue_req(rpq_pkg::OP_SELECT,    8'h00, 15, 0);
    queue_req(rpq_pkg::OP_RESCHED,   8'hFF, 15, 0);
    queue_req(rpq_pkg::OP_SELECT,    8'hFF,  0, 1);
    queue_req(rpq_pkg::OP_INSERT,    8'h55, 10, 0);
    queue_req(rpq_pkg::OP_SET_READY, 8'h37,  3, 0);
    queue_req(rpq_pkg::OP_RESCHED,   8'h55, 15, 1);   // alone in its group
    queue_req(rpq_pkg::OP_SET_READY, 8'h00,  0, 0);
    queue_req(rpq_pkg::OP_SELECT,    8'h00,  0, 0);
    build_random_traffic();

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (request_backlog.size() != 0 || s_tvalid) @(posedge clk);
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
    if (err_count == 0)
      $display("ready_priority_queue_core_tb: done, clean");
    else
      $display("ready_priority_queue_core_tb: done, errors");
    $finish;
  end

  // ---- request driver ----

  always @(negedge clk) begin
    rpq_pkg::req_t nxt;
    if (!rst && (!s_tvalid || s_took)) begin
      if (s_gap > 0) begin
        s_gap--;
        s_tvalid <= 1'b0;
      end else if (request_backlog.size() != 0) begin
        nxt = request_backlog.pop_front();
        s_tdata  <= {3'b000, nxt.ready_req, nxt.priority_req, nxt.req_id};
        s_tuser  <= nxt.op;
        s_tvalid <= 1'b1;
        words_sent++;
        s_gap = draw_wait(words_sent);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---- reply side ready ----

  always @(negedge clk) begin
    if (m_took && replies_seen == HOLD_AT) hold_left = HOLD_LEN;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (m_took) m_wait = draw_wait(replies_seen + 25);
      if (m_wait > 0) begin
        m_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---- monitor, checker and watchdog ----

  always @(posedge clk) begin
    rpq_pkg::req_t r;
    rpq_pkg::res_t got;
    rpq_pkg::res_t want;
    if (rst) begin
      s_took = 1'b0;
      m_took = 1'b0;
    end else begin
      s_took = s_tvalid && s_tready;
      m_took = m_tvalid && m_tready;
      if (s_took) begin
        r.op           = rpq_pkg::op_t'(s_tuser);
        r.req_id       = s_tdata[7:0];
        r.priority_req = s_tdata[11:8];
        r.ready_req    = s_tdata[12];
        owed_replies.push_back(apply_sched_op(r));
      end
      if (m_took) begin
        got.status    = rpq_pkg::status_t'(m_tdata[1:0]);
        got.chosen_id = m_tdata[9:2];
        got.is_empty  = m_tdata[10];
        if (owed_replies.size() == 0) begin
          $display("%0t: reply word with nothing owed, got status %s id %0d empty %0b",
                   $time, got.status.name(), got.chosen_id, got.is_empty);
          err_count++;
        end else begin
          want = owed_replies.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %s got %s", $time,
                     want.status.name(), got.status.name());
            err_count++;
          end
          if (got.chosen_id != want.chosen_id) begin
            $display("%0t: chosen_id expected %0d got %0d", $time,
                     want.chosen_id, got.chosen_id);
            err_count++;
          end
          if (got.is_empty != want.is_empty) begin
            $display("%0t: is_empty expected %0b got %0b", $time,
                     want.is_empty, got.is_empty);
            err_count++;
          end
        end
        replies_seen++;
      end
      if (s_took || m_took) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("ready_priority_queue_core_tb: done, errors");
        $finish;
      end
    end
  end

endmodule
